>>> sv/cfp_pkg.sv
`default_nettype none

package cfp_pkg;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SYNC2,
		PH_LEN,
		PH_CMD,
		PH_DATA,
		PH_CRCLO,
		PH_CRCHI
	} phase_t;

	localparam logic [7:0]  SYNC_FIRST  = 8'h5A;
	localparam logic [7:0]  SYNC_SECOND = 8'hA5;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [7:0]  PCT_MAX     = 8'd100;
	localparam logic [15:0] TEMP_MAX    = 16'd1000;

	localparam logic [7:0] CMD_PUMP     = 8'h01;
	localparam logic [7:0] CMD_MOISTURE = 8'h02;
	localparam logic [7:0] CMD_LINKAGE  = 8'h03;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       line_error;
	} in_item_t;

	typedef struct packed {
		logic        frame_status;
		logic [7:0]  command_code;
		logic        manual_mode;
		logic [6:0]  manual_power;
		logic [7:0]  moisture_threshold;
		logic [7:0]  moisture_hysteresis;
		logic [2:0]  enable_mask;
		logic [9:0]  temp_limit_tenths;
		logic [6:0]  quality_low_limit;
		logic [15:0] good_frames;
		logic [15:0] error_events;
	} result_t;

	// CRC-16/Modbus, one byte, LSB first
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> sv/cfp_stream_if.sv
`default_nettype none

interface cfp_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/command_frame_parser_crc16.sv
// An accepted byte is held in the input stage register and parsed from there; a frame's result
// is registered in the output register when its CRC high byte is parsed.
// Throughput: one byte per cycle; the output register lets a new byte in while a result waits.
// Only a result held in the output register while the parser has another one stalls input.
// Reset (arst_n low, asynchronous): parser hunts for sync, CRC = 0xFFFF, settings and
// counters zero; payload bytes are not reset.
`default_nettype none

module command_frame_parser_crc16
	import cfp_pkg::*;
#(
	parameter int MAX_PAYLOAD = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	cfp_stream_if.sink   items,
	cfp_stream_if.source results
);

	localparam int         LEN_W   = $clog2(MAX_PAYLOAD + 2);
	localparam logic [7:0] LEN_MAX = 8'(MAX_PAYLOAD + 1);
	// commands only ever look at the first four payload bytes
	localparam int         KEPT    = 4;

	// input stage
	logic     valid_s1;
	in_item_t item_s1;

	// parser state
	phase_t            phase_q, phase_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [7:0]        cmd_q, cmd_d;
	logic [LEN_W-1:0]  idx_q, idx_d;
	logic [15:0]       crc_q, crc_d;
	logic [7:0]        crc_lo_q, crc_lo_d;
	logic [7:0]        pay_q [KEPT];
	logic [KEPT-1:0]   pay_we;

	// settings and counters
	logic              mode_q, mode_d;
	logic [6:0]        power_q, power_d;
	logic [7:0]        thr_q, thr_d;
	logic [7:0]        hyst_q, hyst_d;
	logic [2:0]        en_q, en_d;
	logic [9:0]        temp_q, temp_d;
	logic [6:0]        qual_q, qual_d;
	logic [15:0]       good_q, good_d;
	logic [15:0]       err_q, err_d;

	// result register
	logic              res_valid_q;
	result_t           res_q;

	logic              done_c;
	logic              status_c;
	logic              crc_ok;
	logic              fire_s1;
	logic [7:0]        b;
	logic [15:0]       temp_raw;

	assign b        = item_s1.rx_byte;
	assign crc_ok   = ({b, crc_lo_q} == crc_q);
	assign temp_raw = {pay_q[2], pay_q[1]};

	assign fire_s1     = valid_s1 && (!done_c || !res_valid_q || results.ready);
	assign items.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1 <= items.data;
		end
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (b == SYNC_FIRST) phase_d = PH_SYNC2;
			end
			PH_SYNC2: begin
				phase_d = (b == SYNC_SECOND) ? PH_LEN : PH_HUNT;
			end
			PH_LEN: begin
				phase_d = (b == 8'd0 || b > LEN_MAX) ? PH_HUNT : PH_CMD;
			end
			PH_CMD: begin
				phase_d = (len_q <= LEN_W'(1)) ? PH_CRCLO : PH_DATA;
			end
			PH_DATA: begin
				if (idx_q + LEN_W'(2) >= len_q) phase_d = PH_CRCLO;
			end
			PH_CRCLO: begin
				phase_d = PH_CRCHI;
			end
			PH_CRCHI: begin
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// datapath and result
	always_comb begin
		len_d    = len_q;
		cmd_d    = cmd_q;
		idx_d    = idx_q;
		crc_d    = crc_q;
		crc_lo_d = crc_lo_q;
		pay_we   = '0;
		mode_d   = mode_q;
		power_d  = power_q;
		thr_d    = thr_q;
		hyst_d   = hyst_q;
		en_d     = en_q;
		temp_d   = temp_q;
		qual_d   = qual_q;
		good_d   = good_q;
		err_d    = err_q + 16'(item_s1.line_error);
		done_c   = 1'b0;
		status_c = STATUS_OK;
		unique case (phase_q)
			PH_HUNT: begin
				if (b == SYNC_FIRST) crc_d = crc_fold(CRC_INIT, b);
			end
			PH_SYNC2: begin
				if (b == SYNC_SECOND) crc_d = crc_fold(crc_q, b);
			end
			PH_LEN: begin
				if (b != 8'd0 && b <= LEN_MAX) begin
					len_d = b[LEN_W-1:0];
					crc_d = crc_fold(crc_q, b);
				end
			end
			PH_CMD: begin
				cmd_d = b;
				idx_d = '0;
				crc_d = crc_fold(crc_q, b);
			end
			PH_DATA: begin
				if (idx_q < LEN_W'(KEPT)) pay_we[idx_q[1:0]] = 1'b1;
				idx_d = idx_q + LEN_W'(1);
				crc_d = crc_fold(crc_q, b);
			end
			PH_CRCLO: begin
				crc_lo_d = b;
			end
			PH_CRCHI: begin
				done_c = 1'b1;
				if (crc_ok) begin
					good_d = good_q + 16'd1;
					// payload length is len_q - 1
					if (cmd_q == CMD_PUMP && len_q >= LEN_W'(3)) begin
						mode_d  = (pay_q[0] != 8'd0);
						power_d = (pay_q[1] > PCT_MAX) ? PCT_MAX[6:0] : pay_q[1][6:0];
					end else if (cmd_q == CMD_MOISTURE && len_q >= LEN_W'(3)) begin
						thr_d  = pay_q[0];
						hyst_d = pay_q[1];
					end else if (cmd_q == CMD_LINKAGE && len_q >= LEN_W'(5)) begin
						en_d = pay_q[0][2:0];
						if (temp_raw[15]) begin
							temp_d = '0;
						end else if (temp_raw > TEMP_MAX) begin
							temp_d = TEMP_MAX[9:0];
						end else begin
							temp_d = temp_raw[9:0];
						end
						qual_d = (pay_q[3] > PCT_MAX) ? PCT_MAX[6:0] : pay_q[3][6:0];
					end
				end else begin
					status_c = STATUS_BAD;
					err_d    = err_q + 16'(item_s1.line_error) + 16'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			len_q    <= '0;
			cmd_q    <= '0;
			idx_q    <= '0;
			crc_q    <= CRC_INIT;
			crc_lo_q <= '0;
			mode_q   <= 1'b0;
			power_q  <= '0;
			thr_q    <= '0;
			hyst_q   <= '0;
			en_q     <= '0;
			temp_q   <= '0;
			qual_q   <= '0;
			good_q   <= '0;
			err_q    <= '0;
		end else if (fire_s1) begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			cmd_q    <= cmd_d;
			idx_q    <= idx_d;
			crc_q    <= crc_d;
			crc_lo_q <= crc_lo_d;
			mode_q   <= mode_d;
			power_q  <= power_d;
			thr_q    <= thr_d;
			hyst_q   <= hyst_d;
			en_q     <= en_d;
			temp_q   <= temp_d;
			qual_q   <= qual_d;
			good_q   <= good_d;
			err_q    <= err_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < KEPT; i++) begin
			if (fire_s1 && pay_we[i]) pay_q[i] <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1 && done_c) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && done_c) begin
			res_q.frame_status        <= status_c;
			res_q.command_code        <= cmd_q;
			res_q.manual_mode         <= mode_d;
			res_q.manual_power        <= power_d;
			res_q.moisture_threshold  <= thr_d;
			res_q.moisture_hysteresis <= hyst_d;
			res_q.enable_mask         <= en_d;
			res_q.temp_limit_tenths   <= temp_d;
			res_q.quality_low_limit   <= qual_d;
			res_q.good_frames         <= good_d;
			res_q.error_events        <= err_d;
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

endmodule

`default_nettype wire

>>> sv/cfp_checker.sv
`default_nettype none

module cfp_checker
	import cfp_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    in_valid,
	input wire logic    in_ready,
	input wire logic    out_valid,
	input wire logic    out_ready,
	input wire result_t out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	// with the output register empty nothing can block the input stage
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	// a fresh result traces back to a byte taken through the input stage and parsed into the output register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching input transaction");

	// a mismatch always raises the error count, so it cannot read zero right after reset
	a_bad_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_status == STATUS_BAD && $past(!arst_n, 3)
		|-> out_data.error_events != 16'd0)
		else $error("crc mismatch not counted");

endmodule

bind command_frame_parser_crc16 cfp_checker u_cfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.data)
);

`default_nettype wire

>>> tb/tb.sv
module tb;
	import cfp_pkg::*;

	localparam int PAYLOAD_MAX = 16;
	localparam int RANDOM_ITEMS = 1450;
	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD = 400;

	typedef struct {
		in_item_t item;
		bit       drain_first;
	} byte_slot_t;

	logic clk;
	logic arst_n;

	cfp_stream_if #(.data_t(in_item_t)) byte_ch ();
	cfp_stream_if #(.data_t(result_t))  frame_ch ();

	command_frame_parser_crc16 #(
		.MAX_PAYLOAD(PAYLOAD_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.items(byte_ch),
		.results(frame_ch)
	);

	byte_slot_t byte_slots[$];
	result_t    frame_results[$];
	logic [7:0] body_q[$];

	int          queued_items = 0;
	int          mismatch_cnt = 0;
	int          results_seen = 0;
	int          send_gap = 0;
	int          sink_hold = 0;
	int          long_holds = 0;
	logic [31:0] cycle_cnt = '0;
	in_item_t    drv_data;
	logic        drv_valid;

	// parser state as seen from the byte stream
	phase_t      parse_ph = PH_HUNT;
	logic [4:0]  flen = '0;
	logic [7:0]  fcmd = '0;
	logic [7:0]  payload [PAYLOAD_MAX];
	int          pidx = 0;
	logic [15:0] crc_acc = CRC_INIT;
	logic [7:0]  crc_lo = '0;

	// stored settings and counters
	logic        pump_manual = 1'b0;
	logic [6:0]  pump_power = '0;
	logic [7:0]  moist_thr = '0;
	logic [7:0]  moist_hyst = '0;
	logic [2:0]  en_mask = '0;
	logic [9:0]  temp_lim = '0;
	logic [6:0]  qual_lim = '0;
	logic [15:0] good_cnt = '0;
	logic [15:0] err_cnt = '0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// bit-serial form: data bit injected at the feedback tap
	function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			r = (r[0] ^ b[i]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		if (cycle_cnt[9:8] == 2'b11) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic parse_byte(input in_item_t it);
		result_t          r;
		logic [7:0]       b;
		logic signed [15:0] raw;
		int               plen;
		b = it.rx_byte;
		if (it.line_error) begin
			err_cnt++;
		end
		case (parse_ph)
			PH_HUNT: begin
				if (b == SYNC_FIRST) begin
					crc_acc = crc_step(CRC_INIT, b);
					parse_ph = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				if (b == SYNC_SECOND) begin
					crc_acc = crc_step(crc_acc, b);
					parse_ph = PH_LEN;
				end else begin
					parse_ph = PH_HUNT;
				end
			end
			PH_LEN: begin
				if (b == 8'd0 || b > 8'(PAYLOAD_MAX + 1)) begin
					parse_ph = PH_HUNT;
				end else begin
					flen = b[4:0];
					crc_acc = crc_step(crc_acc, b);
					parse_ph = PH_CMD;
				end
			end
			PH_CMD: begin
				fcmd = b;
				pidx = 0;
				crc_acc = crc_step(crc_acc, b);
				parse_ph = (flen <= 5'd1) ? PH_CRCLO : PH_DATA;
			end
			PH_DATA: begin
				if (pidx < PAYLOAD_MAX) begin
					payload[pidx] = b;
				end
				pidx++;
				crc_acc = crc_step(crc_acc, b);
				if (pidx + 1 >= flen) begin
					parse_ph = PH_CRCLO;
				end
			end
			PH_CRCLO: begin
				crc_lo = b;
				parse_ph = PH_CRCHI;
			end
			PH_CRCHI: begin
				plen = flen - 1;
				if ({b, crc_lo} == crc_acc) begin
					if (fcmd == CMD_PUMP && plen >= 2) begin
						pump_manual = (payload[0] != 8'd0);
						pump_power = (payload[1] > PCT_MAX) ? PCT_MAX[6:0] : payload[1][6:0];
					end else if (fcmd == CMD_MOISTURE && plen >= 2) begin
						moist_thr = payload[0];
						moist_hyst = payload[1];
					end else if (fcmd == CMD_LINKAGE && plen >= 4) begin
						en_mask = payload[0][2:0];
						raw = {payload[2], payload[1]};
						if (raw < 0) begin
							temp_lim = '0;
						end else if (raw > 16'sd1000) begin
							temp_lim = 10'd1000;
						end else begin
							temp_lim = raw[9:0];
						end
						qual_lim = (payload[3] > PCT_MAX) ? PCT_MAX[6:0] : payload[3][6:0];
					end
					good_cnt++;
					r.frame_status = STATUS_OK;
				end else begin
					err_cnt++;
					r.frame_status = STATUS_BAD;
				end
				r.command_code = fcmd;
				r.manual_mode = pump_manual;
				r.manual_power = pump_power;
				r.moisture_threshold = moist_thr;
				r.moisture_hysteresis = moist_hyst;
				r.enable_mask = en_mask;
				r.temp_limit_tenths = temp_lim;
				r.quality_low_limit = qual_lim;
				r.good_frames = good_cnt;
				r.error_events = err_cnt;
				frame_results.push_back(r);
				parse_ph = PH_HUNT;
			end
			default: begin
				parse_ph = PH_HUNT;
			end
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 100) begin
			$display("result %0d: %s", results_seen, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
		end
	endtask

	task automatic put_byte(input logic [7:0] b, input logic le, input bit drain);
		byte_slot_t s;
		s.item.rx_byte = b;
		s.item.line_error = le;
		s.drain_first = drain;
		byte_slots.push_back(s);
		queued_items++;
	endtask

	// frame around body_q; body_q is consumed
	task automatic put_frame(input logic [7:0] cmd, input bit bad_crc, input int le_pct,
			input bit drain);
		logic [7:0]  raw_bytes[$];
		logic [15:0] crc;
		raw_bytes.push_back(SYNC_FIRST);
		raw_bytes.push_back(SYNC_SECOND);
		raw_bytes.push_back(8'(body_q.size() + 1));
		raw_bytes.push_back(cmd);
		foreach (body_q[i]) raw_bytes.push_back(body_q[i]);
		crc = CRC_INIT;
		foreach (raw_bytes[i]) crc = crc_step(crc, raw_bytes[i]);
		if (bad_crc) begin
			crc ^= 16'(1 << $urandom_range(0, 15));
		end
		raw_bytes.push_back(crc[7:0]);
		raw_bytes.push_back(crc[15:8]);
		foreach (raw_bytes[i]) begin
			put_byte(raw_bytes[i], $urandom_range(0, 99) < le_pct, drain && i == 0);
		end
		body_q.delete();
	endtask

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
			byte_ch.data <= '0;
		end else begin
			drv_valid = byte_ch.valid;
			drv_data = byte_ch.data;
			if (byte_ch.valid && byte_ch.ready) begin
				parse_byte(byte_ch.data);
				drv_valid = 1'b0;
			end
			if (!drv_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (byte_slots.size() > 0 &&
						!(byte_slots[0].drain_first && frame_results.size() > 0)) begin
					drv_data = byte_slots[0].item;
					drv_valid = 1'b1;
					void'(byte_slots.pop_front());
					send_gap = idle_len();
				end
			end
			byte_ch.valid <= drv_valid;
			byte_ch.data <= drv_data;
		end
	end

	// receiver backpressure; two long hold-offs let the block fill up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_ch.ready <= 1'b0;
			sink_hold = 0;
		end else if (sink_hold > 0) begin
			frame_ch.ready <= 1'b0;
			sink_hold--;
		end else if ((cycle_cnt >= 1500 && long_holds == 0) ||
				(cycle_cnt >= 4000 && long_holds == 1)) begin
			long_holds++;
			frame_ch.ready <= 1'b0;
			sink_hold = LONG_HOLD - 1;
		end else begin
			sink_hold = idle_len();
			if (sink_hold == 0) begin
				frame_ch.ready <= 1'b1;
			end else begin
				frame_ch.ready <= 1'b0;
				sink_hold--;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && frame_ch.valid && frame_ch.ready) begin
			results_seen++;
			if (frame_results.size() == 0) begin
				report_mismatch("result with no frame pending");
			end else begin
				want = frame_results.pop_front();
				check_field("frame_status", 16'(frame_ch.data.frame_status),
					16'(want.frame_status));
				check_field("command_code", 16'(frame_ch.data.command_code),
					16'(want.command_code));
				check_field("manual_mode", 16'(frame_ch.data.manual_mode),
					16'(want.manual_mode));
				check_field("manual_power", 16'(frame_ch.data.manual_power),
					16'(want.manual_power));
				check_field("moisture_threshold", 16'(frame_ch.data.moisture_threshold),
					16'(want.moisture_threshold));
				check_field("moisture_hysteresis", 16'(frame_ch.data.moisture_hysteresis),
					16'(want.moisture_hysteresis));
				check_field("enable_mask", 16'(frame_ch.data.enable_mask),
					16'(want.enable_mask));
				check_field("temp_limit_tenths", 16'(frame_ch.data.temp_limit_tenths),
					16'(want.temp_limit_tenths));
				check_field("quality_low_limit", 16'(frame_ch.data.quality_low_limit),
					16'(want.quality_low_limit));
				check_field("good_frames", frame_ch.data.good_frames, want.good_frames);
				check_field("error_events", frame_ch.data.error_events, want.error_events);
			end
		end
	end

	initial begin
		int          pick;
		int          plen;
		int          frame_no;
		logic [7:0]  cmd;
		logic [15:0] t;
		arst_n = 1'b0;

		// broken sync: the second 5A is not taken as a new start
		put_byte(SYNC_FIRST, 1'b0, 1'b0);
		put_byte(SYNC_FIRST, 1'b0, 1'b0);
		put_byte(SYNC_SECOND, 1'b1, 1'b0);
		// zero and oversize length
		put_byte(SYNC_FIRST, 1'b0, 1'b0);
		put_byte(SYNC_SECOND, 1'b0, 1'b0);
		put_byte(8'd0, 1'b0, 1'b0);
		put_byte(SYNC_FIRST, 1'b0, 1'b0);
		put_byte(SYNC_SECOND, 1'b0, 1'b0);
		put_byte(8'(PAYLOAD_MAX + 2), 1'b0, 1'b0);
		// command only, no payload
		put_frame(CMD_PUMP, 1'b0, 0, 1'b0);
		// power saturates, mode set
		body_q = '{8'hFF, 8'hFF};
		put_frame(CMD_PUMP, 1'b0, 0, 1'b0);
		body_q = '{8'h00, 8'hFF};
		put_frame(CMD_MOISTURE, 1'b0, 0, 1'b0);
		// most negative temperature, quality saturates
		body_q = '{8'hFF, 8'h00, 8'h80, 8'hFF};
		put_frame(CMD_LINKAGE, 1'b0, 0, 1'b0);
		// temperature just above the top
		body_q = '{8'h05, 8'hE9, 8'h03, 8'd100};
		put_frame(CMD_LINKAGE, 1'b0, 0, 1'b0);
		// linkage one byte short
		body_q = '{8'h07, 8'h10, 8'h00};
		put_frame(CMD_LINKAGE, 1'b0, 0, 1'b0);
		// unknown command at full length
		for (int i = 0; i < PAYLOAD_MAX; i++) body_q.push_back(8'($urandom));
		put_frame(8'hFF, 1'b0, 0, 1'b0);
		body_q = '{8'h00, 8'h00};
		put_frame(8'h00, 1'b0, 0, 1'b0);
		// bad CRC with a line error on the closing byte
		body_q = '{8'h12, 8'h34};
		put_frame(CMD_MOISTURE, 1'b1, 0, 1'b0);
		byte_slots[byte_slots.size() - 1].item.line_error = 1'b1;

		frame_no = 0;
		while (queued_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 82) begin
				frame_no++;
				pick = $urandom_range(0, 99);
				cmd = (pick < 30) ? CMD_PUMP : (pick < 55) ? CMD_MOISTURE :
					(pick < 80) ? CMD_LINKAGE : 8'($urandom);
				if ($urandom_range(0, 99) < 80) begin
					plen = (cmd == CMD_LINKAGE) ? 4 : 2;
				end else begin
					plen = $urandom_range(0, PAYLOAD_MAX);
				end
				for (int i = 0; i < plen; i++) body_q.push_back(8'($urandom));
				if (cmd == CMD_PUMP && plen >= 2 && $urandom_range(0, 1)) begin
					body_q[1] = 8'($urandom_range(90, 110));
				end
				if (cmd == CMD_LINKAGE && plen >= 4 && $urandom_range(0, 1)) begin
					t = 16'(int'($urandom_range(0, 1300)) - 100);
					body_q[1] = t[7:0];
					body_q[2] = t[15:8];
					body_q[3] = 8'($urandom_range(90, 110));
				end
				put_frame(cmd, $urandom_range(0, 99) < 8, 2,
					frame_no == 40 || $urandom_range(0, 99) == 0);
			end else if (pick < 91) begin
				repeat ($urandom_range(1, 6)) begin
					put_byte(8'($urandom), $urandom_range(0, 99) < 5, 1'b0);
				end
			end else begin
				put_byte(SYNC_FIRST, 1'b0, 1'b0);
				case ($urandom_range(0, 2))
					0: put_byte(8'($urandom_range(0, 254)) ^ SYNC_SECOND ^ 8'hFF, 1'b0,
						1'b0);
					1: begin
						put_byte(SYNC_SECOND, 1'b0, 1'b0);
						put_byte($urandom_range(0, 1) ? 8'd0 :
							8'($urandom_range(PAYLOAD_MAX + 2, 255)), 1'b0, 1'b0);
					end
					default: begin
						// header only; the following bytes are taken as payload and CRC
						put_byte(SYNC_SECOND, 1'b0, 1'b0);
						put_byte(8'($urandom_range(1, PAYLOAD_MAX + 1)), 1'b0, 1'b0);
						put_byte(CMD_MOISTURE, 1'b0, 1'b0);
					end
				endcase
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_slots.size() > 0 || byte_ch.valid || frame_results.size() > 0) begin
			@(negedge clk);
		end
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0 && frame_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

>>> files.f
sv/cfp_pkg.sv
sv/cfp_stream_if.sv
sv/command_frame_parser_crc16.sv
sv/cfp_checker.sv
tb/tb.sv
